// ===== rtl/bosd_pkg.sv =====
// shared types, opcodes and constants of the bind opcode stream decoder
package bosd_pkg;

    // width of stream positions and name lengths, wraps at this size
    localparam int PositionBits = 32;

    // output queue: must hold the two results one byte can produce
    localparam int QueuePtrBits = 2;
    localparam int QueueDepth   = 1 << QueuePtrBits;

    localparam logic [63:0] PointerSize = 64'd8;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_ULEB,
        PH_SLEB,
        PH_NAME,
        PH_COUNT,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_LL,
        MS_LH,
        MS_HL,
        MS_FIN
    } mul_step_t;

    localparam logic [3:0] OP_NOP             = 4'h0;
    localparam logic [3:0] OP_SET_ORD_IMM     = 4'h1;
    localparam logic [3:0] OP_SET_ORD_ULEB    = 4'h2;
    localparam logic [3:0] OP_SET_ORD_SPECIAL = 4'h3;
    localparam logic [3:0] OP_SET_SYMBOL      = 4'h4;
    localparam logic [3:0] OP_SET_TYPE        = 4'h5;
    localparam logic [3:0] OP_SET_ADDEND      = 4'h6;
    localparam logic [3:0] OP_SET_SEG_OFF     = 4'h7;
    localparam logic [3:0] OP_ADD_OFF         = 4'h8;
    localparam logic [3:0] OP_BIND            = 4'h9;
    localparam logic [3:0] OP_BIND_ADD_ULEB   = 4'hA;
    localparam logic [3:0] OP_BIND_ADD_SCALED = 4'hB;
    localparam logic [3:0] OP_BIND_REPEAT     = 4'hC;

    localparam logic [1:0] KIND_BIND = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         segment;
        logic [63:0]        segment_offset;
        logic signed [31:0] library_ordinal;
        logic [3:0]         bind_type;
        logic signed [63:0] addend;
        logic [3:0]         symbol_flags;
        logic [31:0]        symbol_start;
        logic [31:0]        symbol_length;
        logic [63:0]        repeat_count;
        logic [63:0]        stride;
    } rec_t;

    typedef struct packed {
        logic push_a;
        logic push_b;
    } push_t;

endpackage

// ===== rtl/bind_opcode_stream_decoder_top.sv =====
// top level of the bind opcode stream decoder
// records and status caused by an item are written to the result queue as it is taken; outputs show the queue head
// throughput: one stream byte per cycle; a repeat bind with a nonzero count that is not the last byte holds off input
//   while count * stride is built from three 32x32 partial products
// input also waits while the 4-entry result queue has fewer than two free entries
// reset: asynchronous, active low; parser state to reset values, result queue empty
module bind_opcode_stream_decoder_top (
    input  logic               clk,
    input  logic               rst_n,
    // input channel: one stream byte per item
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         stream_byte,
    input  logic               stream_last,
    // output channel: bind records and end-of-stream status
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [3:0]         segment,
    output logic [63:0]        segment_offset,
    output logic signed [31:0] library_ordinal,
    output logic [3:0]         bind_type,
    output logic signed [63:0] addend,
    output logic [3:0]         symbol_flags,
    output logic [31:0]        symbol_start,
    output logic [31:0]        symbol_length,
    output logic [63:0]        repeat_count,
    output logic [63:0]        stride
);

    logic            accept;
    logic            busy;
    logic            space_ok;
    bosd_pkg::push_t  push;
    bosd_pkg::rec_t   rec_a, rec_b, head;

    // take a byte only when the multiplier is free and two results fit
    assign in_ready = !busy && space_ok;
    assign accept   = in_valid && in_ready;

    // parser: updates binding state and forms up to two results per item
    bosd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream_byte),
        .stream_last (stream_last),
        .busy        (busy),
        .push        (push),
        .rec_a       (rec_a),
        .rec_b       (rec_b)
    );

    // result queue decouples the output stall from the parser
    bosd_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .rec_a      (rec_a),
        .rec_b      (rec_b),
        .space_ok   (space_ok),
        .head_valid (out_valid),
        .pop_ready  (out_ready),
        .head       (head)
    );

    // unpack the queue head onto the output fields
    assign kind            = head.kind;
    assign segment         = head.segment;
    assign segment_offset  = head.segment_offset;
    assign library_ordinal = head.library_ordinal;
    assign bind_type       = head.bind_type;
    assign addend          = head.addend;
    assign symbol_flags    = head.symbol_flags;
    assign symbol_start    = head.symbol_start;
    assign symbol_length   = head.symbol_length;
    assign repeat_count    = head.repeat_count;
    assign stride          = head.stride;

endmodule

// ===== rtl/bosd_outq.sv =====
// small result queue, up to two writes and one read per cycle
module bosd_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  bosd_pkg::push_t push,
    input  bosd_pkg::rec_t  rec_a,
    input  bosd_pkg::rec_t  rec_b,
    output logic           space_ok,
    output logic           head_valid,
    input  logic           pop_ready,
    output bosd_pkg::rec_t  head
);

    bosd_pkg::rec_t q_reg [bosd_pkg::QueueDepth];

    logic [bosd_pkg::QueuePtrBits-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bosd_pkg::QueuePtrBits-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bosd_pkg::QueuePtrBits:0]   cnt_reg, cnt_next;
    logic [bosd_pkg::QueuePtrBits-1:0] wr_ptr_b;
    logic                              pop;

    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;
    // two free entries needed before the next item
    assign space_ok   = (cnt_reg <= (bosd_pkg::QueuePtrBits + 1)'(bosd_pkg::QueueDepth - 2));
    assign wr_ptr_b   = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + bosd_pkg::QueuePtrBits'(push.push_a)
                                 + bosd_pkg::QueuePtrBits'(push.push_b);
        rd_ptr_next = rd_ptr_reg + bosd_pkg::QueuePtrBits'(pop);
        cnt_next    = cnt_reg + (bosd_pkg::QueuePtrBits + 1)'(push.push_a)
                              + (bosd_pkg::QueuePtrBits + 1)'(push.push_b)
                              - (bosd_pkg::QueuePtrBits + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push_a)
        begin
            q_reg[wr_ptr_reg] <= rec_a;
        end
        if (push.push_b)
        begin
            q_reg[wr_ptr_b] <= rec_b;
        end
    end

endmodule

// ===== rtl/bosd_core.sv =====
// opcode parser, binding state and repeat offset multiplier
module bosd_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      stream_byte,
    input  logic            stream_last,
    output logic            busy,
    output bosd_pkg::push_t  push,
    output bosd_pkg::rec_t   rec_a,
    output bosd_pkg::rec_t   rec_b
);

    localparam int PB = bosd_pkg::PositionBits;

    bosd_pkg::phase_t    phase_reg, phase_next;
    bosd_pkg::mul_step_t step_reg, step_next;

    logic [3:0]    op_reg, op_next;
    logic [3:0]    imm_reg, imm_next;
    logic [63:0]   acc_reg, acc_next;
    logic [6:0]    shift_reg, shift_next;
    logic [63:0]   count_reg, count_next;
    logic [31:0]   ordinal_reg, ordinal_next;
    logic [3:0]    type_reg, type_next;
    logic [63:0]   addend_reg, addend_next;
    logic [3:0]    flags_reg, flags_next;
    logic [3:0]    segment_reg, segment_next;
    logic [63:0]   offset_reg, offset_next;
    logic [PB-1:0] name_start_reg, name_start_next;
    logic [PB-1:0] name_len_reg, name_len_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic          failed_reg, failed_next;

    logic [63:0]   mul_a_reg, mul_b_reg, prod_reg;
    logic [63:0]   prod_next;
    logic [31:0]   mul_x, mul_y;
    logic [63:0]   mul_inc;
    logic          mul_start;

    logic [3:0]    opc, imm;
    logic [63:0]   acc_or;
    logic [6:0]    shift_add;
    logic [63:0]   skip_stride;
    logic [63:0]   off_base, off_inc;
    logic          rec_valid;
    logic [63:0]   rec_count, rec_stride;
    bosd_pkg::rec_t bind_rec, status_rec;

    assign opc         = stream_byte[7:4];
    assign imm         = stream_byte[3:0];
    assign acc_or      = acc_reg | ({57'd0, stream_byte[6:0]} << shift_reg[5:0]);
    assign shift_add   = shift_reg + 7'd7;
    assign skip_stride = bosd_pkg::PointerSize + acc_or;
    assign busy        = (step_reg != bosd_pkg::MS_IDLE);

    // multiplier sequencer: next step
    always_comb
    begin
        case (step_reg)
            bosd_pkg::MS_IDLE: step_next = mul_start ? bosd_pkg::MS_LL : bosd_pkg::MS_IDLE;
            bosd_pkg::MS_LL:   step_next = bosd_pkg::MS_LH;
            bosd_pkg::MS_LH:   step_next = bosd_pkg::MS_HL;
            bosd_pkg::MS_HL:   step_next = bosd_pkg::MS_FIN;
            bosd_pkg::MS_FIN:  step_next = bosd_pkg::MS_IDLE;
            default:           step_next = bosd_pkg::MS_IDLE;
        endcase
    end

    // multiplier sequencer: operand select and offset increment
    always_comb
    begin
        mul_x   = '0;
        mul_y   = '0;
        mul_inc = '0;
        case (step_reg)
            bosd_pkg::MS_LL:
            begin
                mul_x = mul_a_reg[31:0];
                mul_y = mul_b_reg[31:0];
            end
            bosd_pkg::MS_LH:
            begin
                mul_x   = mul_a_reg[31:0];
                mul_y   = mul_b_reg[63:32];
                mul_inc = prod_reg;
            end
            bosd_pkg::MS_HL:
            begin
                mul_x   = mul_a_reg[63:32];
                mul_y   = mul_b_reg[31:0];
                mul_inc = {prod_reg[31:0], 32'd0};
            end
            bosd_pkg::MS_FIN:
            begin
                mul_inc = {prod_reg[31:0], 32'd0};
            end
            default:
            begin
                mul_inc = '0;
            end
        endcase
        prod_next = {32'd0, mul_x} * {32'd0, mul_y};
    end

    // byte processing
    always_comb
    begin
        phase_next      = phase_reg;
        op_next         = op_reg;
        imm_next        = imm_reg;
        acc_next        = acc_reg;
        shift_next      = shift_reg;
        count_next      = count_reg;
        ordinal_next    = ordinal_reg;
        type_next       = type_reg;
        addend_next     = addend_reg;
        flags_next      = flags_reg;
        segment_next    = segment_reg;
        name_start_next = name_start_reg;
        name_len_next   = name_len_reg;
        pos_next        = pos_reg;
        failed_next     = failed_reg;
        off_base        = offset_reg;
        off_inc         = mul_inc;
        rec_valid       = 1'b0;
        rec_count       = 64'd1;
        rec_stride      = bosd_pkg::PointerSize;
        mul_start       = 1'b0;

        if (accept)
        begin
            pos_next = pos_reg + 1'b1;
            if (!failed_reg)
            begin
                case (phase_reg)
                    bosd_pkg::PH_OPCODE:
                    begin
                        op_next  = opc;
                        imm_next = imm;
                        acc_next   = '0;
                        shift_next = '0;
                        case (opc)
                            bosd_pkg::OP_NOP: ;
                            bosd_pkg::OP_SET_ORD_IMM: ordinal_next = {28'd0, imm};
                            bosd_pkg::OP_SET_ORD_ULEB: phase_next = bosd_pkg::PH_ULEB;
                            bosd_pkg::OP_SET_ORD_SPECIAL:
                                ordinal_next = (imm == 4'd0) ? 32'd0 : {28'hfffffff, imm};
                            bosd_pkg::OP_SET_SYMBOL:
                            begin
                                flags_next      = imm;
                                name_start_next = pos_reg + 1'b1;
                                name_len_next   = '0;
                                phase_next      = bosd_pkg::PH_NAME;
                            end
                            bosd_pkg::OP_SET_TYPE: type_next = imm;
                            bosd_pkg::OP_SET_ADDEND: phase_next = bosd_pkg::PH_SLEB;
                            bosd_pkg::OP_SET_SEG_OFF: phase_next = bosd_pkg::PH_ULEB;
                            bosd_pkg::OP_ADD_OFF: phase_next = bosd_pkg::PH_ULEB;
                            bosd_pkg::OP_BIND:
                            begin
                                rec_valid = 1'b1;
                                off_inc   = bosd_pkg::PointerSize;
                            end
                            bosd_pkg::OP_BIND_ADD_ULEB:
                            begin
                                rec_valid  = 1'b1;
                                phase_next = bosd_pkg::PH_ULEB;
                            end
                            bosd_pkg::OP_BIND_ADD_SCALED:
                            begin
                                rec_valid = 1'b1;
                                off_inc   = bosd_pkg::PointerSize + {57'd0, imm, 3'd0};
                            end
                            bosd_pkg::OP_BIND_REPEAT: phase_next = bosd_pkg::PH_COUNT;
                            default: failed_next = 1'b1;
                        endcase
                    end
                    bosd_pkg::PH_ULEB:
                    begin
                        acc_next = acc_or;
                        if (!stream_byte[7])
                        begin
                            phase_next = bosd_pkg::PH_OPCODE;
                            case (op_reg)
                                bosd_pkg::OP_SET_ORD_ULEB: ordinal_next = acc_or[31:0];
                                bosd_pkg::OP_SET_SEG_OFF:
                                begin
                                    segment_next = imm_reg;
                                    off_base     = '0;
                                    off_inc      = acc_or;
                                end
                                bosd_pkg::OP_ADD_OFF: off_inc = acc_or;
                                default: off_inc = bosd_pkg::PointerSize + acc_or;
                            endcase
                        end
                        else
                        begin
                            shift_next = shift_add;
                            if (shift_add[6])
                            begin
                                failed_next = 1'b1;
                            end
                        end
                    end
                    bosd_pkg::PH_SLEB:
                    begin
                        shift_next = shift_add;
                        if (!stream_byte[7])
                        begin
                            // sign fill above the last group when it fits
                            if (!shift_add[6] && stream_byte[6])
                            begin
                                acc_next = acc_or | ({64{1'b1}} << shift_add[5:0]);
                            end
                            else
                            begin
                                acc_next = acc_or;
                            end
                            addend_next = acc_next;
                            phase_next  = bosd_pkg::PH_OPCODE;
                        end
                        else
                        begin
                            acc_next = acc_or;
                            if (shift_add[6])
                            begin
                                failed_next = 1'b1;
                            end
                        end
                    end
                    bosd_pkg::PH_NAME:
                    begin
                        if (stream_byte == 8'd0)
                        begin
                            phase_next = bosd_pkg::PH_OPCODE;
                        end
                        else
                        begin
                            name_len_next = name_len_reg + 1'b1;
                        end
                    end
                    bosd_pkg::PH_COUNT:
                    begin
                        acc_next = acc_or;
                        if (!stream_byte[7])
                        begin
                            count_next = acc_or;
                            acc_next   = '0;
                            shift_next = '0;
                            phase_next = bosd_pkg::PH_SKIP;
                        end
                        else
                        begin
                            shift_next = shift_add;
                            if (shift_add[6])
                            begin
                                failed_next = 1'b1;
                            end
                        end
                    end
                    bosd_pkg::PH_SKIP:
                    begin
                        acc_next = acc_or;
                        if (!stream_byte[7])
                        begin
                            phase_next = bosd_pkg::PH_OPCODE;
                            rec_count  = count_reg;
                            rec_stride = skip_stride;
                            if (count_reg != 64'd0)
                            begin
                                rec_valid = 1'b1;
                                mul_start = !stream_last;
                            end
                        end
                        else
                        begin
                            shift_next = shift_add;
                            if (shift_add[6])
                            begin
                                failed_next = 1'b1;
                            end
                        end
                    end
                    default: failed_next = 1'b1;
                endcase
            end
        end

        offset_next = off_base + off_inc;

        // status record from the state this byte leaves behind
        status_rec      = '0;
        status_rec.kind = (failed_next || (phase_next != bosd_pkg::PH_OPCODE)) ?
                          bosd_pkg::KIND_BAD : bosd_pkg::KIND_DONE;

        if (accept && stream_last)
        begin
            phase_next      = bosd_pkg::PH_OPCODE;
            op_next         = '0;
            imm_next        = '0;
            acc_next        = '0;
            shift_next      = '0;
            count_next      = '0;
            ordinal_next    = '0;
            type_next       = 4'd1;
            addend_next     = '0;
            flags_next      = '0;
            segment_next    = '0;
            offset_next     = '0;
            name_start_next = '0;
            name_len_next   = '0;
            pos_next        = '0;
            failed_next     = 1'b0;
        end
    end

    always_comb
    begin
        bind_rec.kind            = bosd_pkg::KIND_BIND;
        bind_rec.segment         = segment_reg;
        bind_rec.segment_offset  = offset_reg;
        bind_rec.library_ordinal = ordinal_reg;
        bind_rec.bind_type       = type_reg;
        bind_rec.addend          = addend_reg;
        bind_rec.symbol_flags    = flags_reg;
        bind_rec.symbol_start    = 32'(name_start_reg);
        bind_rec.symbol_length   = 32'(name_len_reg);
        bind_rec.repeat_count    = rec_count;
        bind_rec.stride          = rec_stride;

        push.push_a = accept && (rec_valid || stream_last);
        push.push_b = accept && rec_valid && stream_last;
        rec_a       = rec_valid ? bind_rec : status_rec;
        rec_b       = status_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= bosd_pkg::PH_OPCODE;
            step_reg       <= bosd_pkg::MS_IDLE;
            op_reg         <= '0;
            imm_reg        <= '0;
            acc_reg        <= '0;
            shift_reg      <= '0;
            count_reg      <= '0;
            ordinal_reg    <= '0;
            type_reg       <= 4'd1;
            addend_reg     <= '0;
            flags_reg      <= '0;
            segment_reg    <= '0;
            offset_reg     <= '0;
            name_start_reg <= '0;
            name_len_reg   <= '0;
            pos_reg        <= '0;
            failed_reg     <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            step_reg       <= step_next;
            op_reg         <= op_next;
            imm_reg        <= imm_next;
            acc_reg        <= acc_next;
            shift_reg      <= shift_next;
            count_reg      <= count_next;
            ordinal_reg    <= ordinal_next;
            type_reg       <= type_next;
            addend_reg     <= addend_next;
            flags_reg      <= flags_next;
            segment_reg    <= segment_next;
            offset_reg     <= offset_next;
            name_start_reg <= name_start_next;
            name_len_reg   <= name_len_next;
            pos_reg        <= pos_next;
            failed_reg     <= failed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            mul_a_reg <= count_reg;
            mul_b_reg <= skip_stride;
        end
        prod_reg <= prod_next;
    end

endmodule

// ===== test/bosd_tb_pkg.sv =====
// scoreboard that decodes the bind opcode stream alongside the block and matches its results
package bosd_tb_pkg;

    typedef enum logic [1:0] {
        LEB_MORE,
        LEB_DONE,
        LEB_OVERLONG
    } leb_step_t;

    class bind_record_tracker;
        bosd_pkg::rec_t   records_due[$];
        int unsigned      mismatch_count;
        int unsigned      binds_matched;
        int unsigned      clean_ends;
        int unsigned      bad_ends;

        bosd_pkg::phase_t phase;
        logic [3:0]       held_op;
        logic [3:0]       held_imm;
        logic [63:0]      acc;
        logic [6:0]       shift;
        logic [63:0]      count_held;
        logic [31:0]      ordinal;
        logic [3:0]       btype;
        logic [63:0]      addend_now;
        logic [3:0]       flags;
        logic [3:0]       seg;
        logic [63:0]      offset;
        logic [31:0]      name_pos;
        logic [31:0]      name_len;
        logic [31:0]      position;
        bit               failed;

        function new();
            mismatch_count = 0;
            binds_matched  = 0;
            clean_ends     = 0;
            bad_ends       = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            phase      = bosd_pkg::PH_OPCODE;
            held_op    = '0;
            held_imm   = '0;
            acc        = '0;
            shift      = '0;
            count_held = '0;
            ordinal    = '0;
            btype      = 4'd1;
            addend_now = '0;
            flags      = '0;
            seg        = '0;
            offset     = '0;
            name_pos   = '0;
            name_len   = '0;
            position   = '0;
            failed     = 1'b0;
        endfunction

        function void start_number(bosd_pkg::phase_t next);
            acc   = '0;
            shift = '0;
            phase = next;
        endfunction

        function leb_step_t take_uleb(logic [7:0] b);
            acc = acc | (64'(b[6:0]) << shift[5:0]);
            if (!b[7])
                return LEB_DONE;
            shift = shift + 7'd7;
            return (shift >= 7'd64) ? LEB_OVERLONG : LEB_MORE;
        endfunction

        function leb_step_t take_sleb(logic [7:0] b);
            acc = acc | (64'(b[6:0]) << shift[5:0]);
            shift = shift + 7'd7;
            if (!b[7])
            begin
                // sign extension only while the shift is still inside the word
                if (shift < 7'd64 && b[6])
                    acc = acc | ({64{1'b1}} << shift);
                return LEB_DONE;
            end
            return (shift >= 7'd64) ? LEB_OVERLONG : LEB_MORE;
        endfunction

        function void emit_bind(logic [63:0] count, logic [63:0] pitch);
            bosd_pkg::rec_t r;
            r.kind            = bosd_pkg::KIND_BIND;
            r.segment         = seg;
            r.segment_offset  = offset;
            r.library_ordinal = ordinal;
            r.bind_type       = btype;
            r.addend          = addend_now;
            r.symbol_flags    = flags;
            r.symbol_start    = name_pos;
            r.symbol_length   = name_len;
            r.repeat_count    = count;
            r.stride          = pitch;
            records_due.insert(records_due.size(), r);
        endfunction

        function void decode_opcode(logic [7:0] b);
            held_op  = b[7:4];
            held_imm = b[3:0];
            case (b[7:4])
                bosd_pkg::OP_NOP: ;
                bosd_pkg::OP_SET_ORD_IMM:  ordinal = {28'd0, b[3:0]};
                bosd_pkg::OP_SET_ORD_ULEB: start_number(bosd_pkg::PH_ULEB);
                bosd_pkg::OP_SET_ORD_SPECIAL:
                    ordinal = (b[3:0] == 4'd0) ? 32'd0 : {28'hfffffff, b[3:0]};
                bosd_pkg::OP_SET_SYMBOL:
                begin
                    flags    = b[3:0];
                    name_pos = position + 32'd1;
                    name_len = '0;
                    phase    = bosd_pkg::PH_NAME;
                end
                bosd_pkg::OP_SET_TYPE:     btype = b[3:0];
                bosd_pkg::OP_SET_ADDEND:   start_number(bosd_pkg::PH_SLEB);
                bosd_pkg::OP_SET_SEG_OFF:  start_number(bosd_pkg::PH_ULEB);
                bosd_pkg::OP_ADD_OFF:      start_number(bosd_pkg::PH_ULEB);
                bosd_pkg::OP_BIND:
                begin
                    emit_bind(64'd1, bosd_pkg::PointerSize);
                    offset = offset + bosd_pkg::PointerSize;
                end
                bosd_pkg::OP_BIND_ADD_ULEB:
                begin
                    // record goes out now, the offset moves once the operand is complete
                    emit_bind(64'd1, bosd_pkg::PointerSize);
                    start_number(bosd_pkg::PH_ULEB);
                end
                bosd_pkg::OP_BIND_ADD_SCALED:
                begin
                    emit_bind(64'd1, bosd_pkg::PointerSize);
                    offset = offset + bosd_pkg::PointerSize
                           + 64'(b[3:0]) * bosd_pkg::PointerSize;
                end
                bosd_pkg::OP_BIND_REPEAT:  start_number(bosd_pkg::PH_COUNT);
                default:                   failed = 1'b1;
            endcase
        endfunction

        function void finish_uleb();
            case (held_op)
                bosd_pkg::OP_SET_ORD_ULEB: ordinal = acc[31:0];
                bosd_pkg::OP_SET_SEG_OFF:
                begin
                    seg    = held_imm;
                    offset = acc;
                end
                bosd_pkg::OP_ADD_OFF:      offset = offset + acc;
                default:                   offset = offset + bosd_pkg::PointerSize + acc;
            endcase
            phase = bosd_pkg::PH_OPCODE;
        endfunction

        // advance the decoder by one accepted stream byte and queue what it yields
        function void decode_byte(logic [7:0] b, logic last);
            leb_step_t      st;
            logic [63:0]    pitch;
            bosd_pkg::rec_t status;
            if (!failed)
            begin
                case (phase)
                    bosd_pkg::PH_OPCODE: decode_opcode(b);
                    bosd_pkg::PH_ULEB:
                    begin
                        st = take_uleb(b);
                        if (st == LEB_DONE)
                            finish_uleb();
                        else if (st == LEB_OVERLONG)
                            failed = 1'b1;
                    end
                    bosd_pkg::PH_SLEB:
                    begin
                        st = take_sleb(b);
                        if (st == LEB_DONE)
                        begin
                            addend_now = acc;
                            phase      = bosd_pkg::PH_OPCODE;
                        end
                        else if (st == LEB_OVERLONG)
                            failed = 1'b1;
                    end
                    bosd_pkg::PH_NAME:
                    begin
                        if (b == 8'h00)
                            phase = bosd_pkg::PH_OPCODE;
                        else
                            name_len = name_len + 32'd1;
                    end
                    bosd_pkg::PH_COUNT:
                    begin
                        st = take_uleb(b);
                        if (st == LEB_DONE)
                        begin
                            count_held = acc;
                            start_number(bosd_pkg::PH_SKIP);
                        end
                        else if (st == LEB_OVERLONG)
                            failed = 1'b1;
                    end
                    bosd_pkg::PH_SKIP:
                    begin
                        st = take_uleb(b);
                        if (st == LEB_DONE)
                        begin
                            pitch = bosd_pkg::PointerSize + acc;
                            if (count_held != 64'd0)
                                emit_bind(count_held, pitch);
                            offset = offset + count_held * pitch;
                            phase  = bosd_pkg::PH_OPCODE;
                        end
                        else if (st == LEB_OVERLONG)
                            failed = 1'b1;
                    end
                    default: failed = 1'b1;
                endcase
            end
            position = position + 32'd1;

            if (last)
            begin
                status      = '0;
                status.kind = (failed || phase != bosd_pkg::PH_OPCODE) ?
                              bosd_pkg::KIND_BAD : bosd_pkg::KIND_DONE;
                records_due.insert(records_due.size(), status);
                clear_parser();
            end
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            mismatch_count++;
            $display("mismatch in %s: got %h, expected %h", what, got, want);
        endtask

        task match_output(bosd_pkg::rec_t got);
            bosd_pkg::rec_t want;
            if (records_due.size() == 0)
            begin
                report_mismatch("kind of a result nobody expected", 64'(got.kind), '0);
                return;
            end
            want = records_due.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", 64'(got.kind), 64'(want.kind));
            if (got.segment !== want.segment)
                report_mismatch("segment", 64'(got.segment), 64'(want.segment));
            if (got.segment_offset !== want.segment_offset)
                report_mismatch("segment_offset", got.segment_offset, want.segment_offset);
            if (got.library_ordinal !== want.library_ordinal)
                report_mismatch("library_ordinal", 64'(got.library_ordinal),
                                64'(want.library_ordinal));
            if (got.bind_type !== want.bind_type)
                report_mismatch("bind_type", 64'(got.bind_type), 64'(want.bind_type));
            if (got.addend !== want.addend)
                report_mismatch("addend", got.addend, want.addend);
            if (got.symbol_flags !== want.symbol_flags)
                report_mismatch("symbol_flags", 64'(got.symbol_flags), 64'(want.symbol_flags));
            if (got.symbol_start !== want.symbol_start)
                report_mismatch("symbol_start", 64'(got.symbol_start), 64'(want.symbol_start));
            if (got.symbol_length !== want.symbol_length)
                report_mismatch("symbol_length", 64'(got.symbol_length),
                                64'(want.symbol_length));
            if (got.repeat_count !== want.repeat_count)
                report_mismatch("repeat_count", got.repeat_count, want.repeat_count);
            if (got.stride !== want.stride)
                report_mismatch("stride", got.stride, want.stride);

            if (want.kind == bosd_pkg::KIND_BIND)
                binds_matched++;
            else if (want.kind == bosd_pkg::KIND_DONE)
                clean_ends++;
            else
                bad_ends++;
        endtask

        task close_out();
            if (records_due.size() != 0)
                report_mismatch("count of results never delivered", 64'(records_due.size()), '0);
        endtask

        function int unsigned waiting();
            return records_due.size();
        endfunction
    endclass

endpackage

// ===== test/bind_opcode_stream_decoder_top_tb.sv =====
// self-checking testbench for the bind opcode stream decoder top level
module bind_opcode_stream_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 12;
    // long receiver hold-off, well past what it takes to fill the result queue
    localparam int LONG_HOLD    = 400;
    // results pass through the result queue after their byte; a short tail catches strays
    localparam int DRAIN_CYCLES = 20;
    // the limit is set to hold a correct run even with two results per byte,
    // half the cycles stalled on each side and the repeat multiply stalls
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 340;

    // opcodes the block rejects
    localparam logic [3:0] OP_FIRST_BAD = 4'hD;
    localparam logic [3:0] OP_LAST_BAD  = 4'hF;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         stream_byte;
    logic               stream_last;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         kind;
    logic [3:0]         segment;
    logic [63:0]        segment_offset;
    logic signed [31:0] library_ordinal;
    logic [3:0]         bind_type;
    logic signed [63:0] addend;
    logic [3:0]         symbol_flags;
    logic [31:0]        symbol_start;
    logic [31:0]        symbol_length;
    logic [63:0]        repeat_count;
    logic [63:0]        stride;

    bosd_pkg::rec_t                 seen_rec;
    bosd_tb_pkg::bind_record_tracker board;

    // byte stream under construction, sent as one stream with last on its final byte
    logic [7:0]         stream_q[$];
    int unsigned        items_sent;
    int unsigned        streams_sent;
    int unsigned        cycle_count;
    int                 send_idle;
    int                 recv_idle;
    logic               hold_go;
    logic               hold_output;

    bind_opcode_stream_decoder_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .stream_byte     (stream_byte),
        .stream_last     (stream_last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .segment         (segment),
        .segment_offset  (segment_offset),
        .library_ordinal (library_ordinal),
        .bind_type       (bind_type),
        .addend          (addend),
        .symbol_flags    (symbol_flags),
        .symbol_start    (symbol_start),
        .symbol_length   (symbol_length),
        .repeat_count    (repeat_count),
        .stride          (stride)
    );

    // result fields gathered in record order for the scoreboard
    assign seen_rec = {kind, segment, segment_offset, library_ordinal, bind_type, addend,
                       symbol_flags, symbol_start, symbol_length, repeat_count, stride};

    // free-running clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // watchdog: a hung handshake ends the run here
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still due", cycle_count, board.waiting());
        $display("TEST FAILED");
        $finish;
    end

    // receiver: check every accepted result, then decide ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.match_output(seen_rec);
        out_ready <= !hold_output && ($urandom_range(99) >= recv_idle);
    end

    // long hold-off on the output, counted here so the sender keeps pushing meanwhile
    initial
    begin : long_stall
        hold_output = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_output <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_output <= 1'b0;
    end

    // offer one item, with random gaps first, and hand it to the scoreboard on acceptance
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        stream_byte <= b;
        stream_last <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.decode_byte(b, last);
        items_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1);
        streams_sent++;
    endtask

    // append one byte to the stream under construction
    function automatic void add_byte(logic [7:0] b);
        stream_q.insert(stream_q.size(), b);
    endfunction

    // operand values: mostly small, some 32-bit, some full width, some extremes
    function automatic logic [63:0] pick_number();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return 64'($urandom_range(300));
        if (sel < 7)
            return 64'($urandom);
        if (sel < 9)
            return {$urandom, $urandom};
        sel = $urandom_range(2);
        if (sel == 0)
            return 64'd0;
        if (sel == 1)
            return {64{1'b1}};
        return 64'h8000_0000_0000_0000;
    endfunction

    // unsigned leb128, sometimes padded with redundant continuation bytes (ten at most)
    function automatic void put_uleb(logic [63:0] v);
        int         n;
        int         pad_to;
        logic [7:0] b;
        n      = 0;
        pad_to = ($urandom_range(3) == 0) ? $urandom_range(1, 10) : 1;
        do
        begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            n++;
            if (v != 0 || n < pad_to)
                b[7] = 1'b1;
            add_byte(b);
        end
        while (b[7]);
    endfunction

    // signed leb128, minimal length
    function automatic void put_sleb(logic signed [63:0] v);
        logic [7:0] b;
        bit         more;
        do
        begin
            b    = {1'b0, v[6:0]};
            v    = v >>> 7;
            more = !((v == 0 && !b[6]) || (v == -1 && b[6]));
            if (more)
                b[7] = 1'b1;
            add_byte(b);
        end
        while (more);
    endfunction

    // number whose continuation runs past 64 bits of shift
    function automatic void put_overlong();
        repeat ($urandom_range(10, 12))
            add_byte({1'b1, 7'($urandom)});
    endfunction

    // one well-formed opcode with its operands and random content
    function automatic void put_command();
        int         pick;
        logic [3:0] imm;
        pick = $urandom_range(99);
        imm  = 4'($urandom);
        if (pick < 8)
            add_byte({bosd_pkg::OP_SET_ORD_IMM, imm});
        else if (pick < 14)
        begin
            add_byte({bosd_pkg::OP_SET_ORD_ULEB, imm});
            put_uleb(pick_number());
        end
        else if (pick < 19)
            add_byte({bosd_pkg::OP_SET_ORD_SPECIAL, imm});
        else if (pick < 27)
        begin
            add_byte({bosd_pkg::OP_SET_SYMBOL, imm});
            repeat ($urandom_range(5))
                add_byte(8'($urandom_range(1, 255)));
            add_byte(8'h00);
        end
        else if (pick < 32)
            add_byte({bosd_pkg::OP_SET_TYPE, imm});
        else if (pick < 40)
        begin
            add_byte({bosd_pkg::OP_SET_ADDEND, imm});
            put_sleb(pick_number());
        end
        else if (pick < 48)
        begin
            add_byte({bosd_pkg::OP_SET_SEG_OFF, imm});
            put_uleb(pick_number());
        end
        else if (pick < 54)
        begin
            add_byte({bosd_pkg::OP_ADD_OFF, imm});
            put_uleb(pick_number());
        end
        else if (pick < 68)
            add_byte({bosd_pkg::OP_BIND, imm});
        else if (pick < 76)
        begin
            add_byte({bosd_pkg::OP_BIND_ADD_ULEB, imm});
            put_uleb(pick_number());
        end
        else if (pick < 84)
            add_byte({bosd_pkg::OP_BIND_ADD_SCALED, imm});
        else if (pick < 96)
        begin
            // count of zero now and then, which binds nothing
            add_byte({bosd_pkg::OP_BIND_REPEAT, imm});
            put_uleb(($urandom_range(5) == 0) ? 64'd0 : pick_number());
            put_uleb(pick_number());
        end
        else
            add_byte({bosd_pkg::OP_NOP, imm});
    endfunction

    // mostly well-formed streams; some truncated, corrupted, overlong or plain noise
    task automatic send_random_stream();
        int shape;
        int keep;
        stream_q.delete();
        repeat ($urandom_range(1, 12))
            put_command();
        shape = $urandom_range(99);
        if (shape < 6)
        begin
            // truncated: ends inside whatever the cut lands on
            keep = $urandom_range(1, stream_q.size());
            while (stream_q.size() > keep)
                void'(stream_q.pop_back());
        end
        else if (shape < 10)
        begin
            stream_q.insert($urandom_range(stream_q.size()),
                            {4'($urandom_range(OP_LAST_BAD, OP_FIRST_BAD)), 4'($urandom)});
            add_byte({bosd_pkg::OP_NOP, 4'($urandom)});
        end
        else if (shape < 13)
        begin
            add_byte(($urandom_range(1) == 0) ? {bosd_pkg::OP_ADD_OFF, 4'($urandom)}
                                              : {bosd_pkg::OP_SET_ADDEND, 4'($urandom)});
            put_overlong();
            put_command();
        end
        else if (shape < 16)
        begin
            stream_q.delete();
            repeat ($urandom_range(1, 8))
                add_byte(8'($urandom));
        end
        else if (shape >= 25)
            add_byte({bosd_pkg::OP_NOP, 4'($urandom)});
        // otherwise the final command itself carries last
        send_stream();
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < count)
            send_random_stream();
    endtask

    task automatic send_directed();
        // every opcode, field extremes, padded operand, zero repeat, bind on the last byte
        stream_q = '{{bosd_pkg::OP_SET_ORD_IMM, 4'hF}, {bosd_pkg::OP_SET_ORD_SPECIAL, 4'hF},
                     {bosd_pkg::OP_SET_TYPE, 4'hF}, {bosd_pkg::OP_SET_SYMBOL, 4'hF},
                     8'h41, 8'h00, {bosd_pkg::OP_SET_ADDEND, 4'h0}, 8'h7F,
                     {bosd_pkg::OP_SET_SEG_OFF, 4'hF}, 8'h00, {bosd_pkg::OP_BIND, 4'h0},
                     {bosd_pkg::OP_BIND_ADD_SCALED, 4'hF}, {bosd_pkg::OP_BIND_ADD_ULEB, 4'h0},
                     8'h85, 8'h00, {bosd_pkg::OP_BIND_REPEAT, 4'h0}, 8'h02, 8'h00,
                     {bosd_pkg::OP_BIND_REPEAT, 4'h0}, 8'h00, 8'h07,
                     {bosd_pkg::OP_SET_ORD_ULEB, 4'h0}, 8'h7F, {bosd_pkg::OP_ADD_OFF, 4'h0},
                     8'h01, {bosd_pkg::OP_SET_ORD_SPECIAL, 4'h0}, {bosd_pkg::OP_NOP, 4'hF},
                     {bosd_pkg::OP_BIND_ADD_SCALED, 4'h0}};
        send_stream();
        // overlong offset operand, rest ignored until last
        stream_q = '{{bosd_pkg::OP_ADD_OFF, 4'h0}, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_stream();
        // bad opcode, then a bind that must not produce a record
        stream_q = '{{OP_FIRST_BAD, 4'h0}, {bosd_pkg::OP_BIND, 4'h0}};
        send_stream();
        // symbol name cut off by the last byte
        stream_q = '{{bosd_pkg::OP_SET_SYMBOL, 4'h1}, 8'h61};
        send_stream();
    endtask

    initial
    begin : stimulus
        board        = new();
        items_sent   = 0;
        streams_sent = 0;
        send_idle    = 33;
        recv_idle    = 50;
        hold_go      = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        stream_byte  = 8'h00;
        stream_last  = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles a third of the time, receiver half
        send_directed();
        run_random(PHASE_ITEMS);

        // roles swapped
        send_idle = 50;
        recv_idle <= 33;
        run_random(PHASE_ITEMS);

        // full rate both ways, with the long output hold-off to back up the input
        send_idle = 0;
        recv_idle <= 0;
        hold_go   <= 1'b1;
        run_random(PHASE_ITEMS);
        in_valid <= 1'b0;

        // drain everything still owed, then watch a little longer for strays
        while (board.waiting() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        board.close_out();

        $display("ran %0d stream bytes in %0d streams over %0d cycles",
                 items_sent, streams_sent, cycle_count);
        $display("matched %0d bind records, %0d clean ends, %0d malformed ends; %0d mismatches",
                 board.binds_matched, board.clean_ends, board.bad_ends, board.mismatch_count);
        if (board.mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
